// ===== hw/rtl/lrpf_pkg.sv =====
// Shared constants and types for the paged line rasterizer.
`default_nettype none
package lrpf_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int PAGE_COUNT    = 8;
  localparam int ROWS_PER_PAGE = 8;
  localparam int STORE_DEPTH   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int SCREEN_ROWS   = PAGE_COUNT * ROWS_PER_PAGE;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int COL_W  = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int ROW_W  = $clog2(ROWS_PER_PAGE);

  localparam int COORD_W = 12;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;

  // Frame store access request.
  typedef struct packed {
    logic  valid;
    logic  write;
    addr_t addr;
    logic [ROWS_PER_PAGE-1:0] mask;
    logic  on;
  } lrpf_req_t;

  // Frame store read response.
  typedef struct packed {
    logic valid;
    logic [ROWS_PER_PAGE-1:0] data;
  } lrpf_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lrpf_if.sv =====
// Channel interfaces: command in, read byte out.
`default_nettype none
interface lrpf_cmd_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic signed [11:0] start_x;
  logic signed [11:0] start_y;
  logic signed [11:0] end_x;
  logic signed [11:0] end_y;
  logic        pixel_on;
  logic [2:0]  read_page;
  logic [6:0]  read_column;

  modport source (output valid, operation, start_x, start_y, end_x, end_y, pixel_on,
                  read_page, read_column, input ready);
  modport sink (input valid, operation, start_x, start_y, end_x, end_y, pixel_on,
                read_page, read_column, output ready);
endinterface

interface lrpf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;

  modport source (output valid, read_byte, input ready);
  modport sink (input valid, read_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lrpf_frame_store.sv =====
// Paged frame store memory with read-modify-write pipe and clear after reset.
`default_nettype none
module lrpf_frame_store
  import lrpf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire lrpf_req_t req,
  output lrpf_rsp_t      rsp,
  output logic           clearing
);

  logic [ROWS_PER_PAGE-1:0] mem [STORE_DEPTH];
  logic [ROWS_PER_PAGE-1:0] rdata;
  addr_t                    clr_addr;

  lrpf_req_t                s2;
  logic                     fwd_valid;
  addr_t                    fwd_addr;
  logic [ROWS_PER_PAGE-1:0] fwd_data;

  logic [ROWS_PER_PAGE-1:0] base;
  logic [ROWS_PER_PAGE-1:0] wdata;

  // previous write lands at the same edge as this entry's read
  assign base  = (fwd_valid && fwd_addr == s2.addr) ? fwd_data : rdata;
  assign wdata = s2.on ? (base | s2.mask) : (base & ~s2.mask);

  assign rsp.valid = s2.valid && !s2.write;
  assign rsp.data  = base;

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (s2.valid && s2.write) begin
      mem[s2.addr] <= wdata;
    end
    rdata <= mem[req.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      s2.valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + addr_t'(1);
        if (clr_addr == addr_t'(STORE_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      s2.valid  <= req.valid && !clearing;
      fwd_valid <= s2.valid && s2.write;
    end
    s2.write <= req.write;
    s2.addr  <= req.addr;
    s2.mask  <= req.mask;
    s2.on    <= req.on;
    fwd_addr <= s2.addr;
    fwd_data <= wdata;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lrpf_line_walker.sv =====
// Bresenham stepper: one pixel per cycle, clipped to the screen.
`default_nettype none
module lrpf_line_walker
  import lrpf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [11:0] start_x,
  input  wire logic signed [11:0] start_y,
  input  wire logic signed [11:0] end_x,
  input  wire logic signed [11:0] end_y,
  input  wire logic               pixel_on,
  output lrpf_req_t               px,
  output logic                    busy,
  output logic                    done
);

  logic signed [COORD_W-1:0] x, y, ex, ey;
  logic [COORD_W:0]          dx, dy;
  logic                      step_xneg, step_yneg;
  logic signed [COORD_W+1:0] err;
  logic                      on;

  logic signed [COORD_W:0]   ddx, ddy;
  logic [COORD_W:0]          adx, ady;
  logic signed [COORD_W+1:0] err_init;
  logic signed [COORD_W+1:0] dx_s, dy_s;
  logic                      xstep, ystep, at_end, on_screen;
  logic signed [COORD_W+1:0] err_next;

  assign ddx = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
  assign ddy = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
  assign adx = ddx[COORD_W] ? (COORD_W+1)'(1) + ~ddx : ddx;
  assign ady = ddy[COORD_W] ? (COORD_W+1)'(1) + ~ddy : ddy;
  assign err_init = (adx > ady) ? $signed({2'b00, adx[COORD_W:1]})
                                : -$signed({2'b00, ady[COORD_W:1]});

  assign dx_s  = $signed({1'b0, dx});
  assign dy_s  = $signed({1'b0, dy});
  assign xstep = (err + dx_s) > 0;
  assign ystep = err < dy_s;
  assign err_next = err - (xstep ? dy_s : '0) + (ystep ? dx_s : '0);
  assign at_end = (x == ex) && (y == ey);

  assign on_screen = (x >= 0) && (x < SCREEN_WIDTH) && (y >= 0) && (y < SCREEN_ROWS);

  assign px.valid = busy && on_screen;
  assign px.write = 1'b1;
  assign px.addr  = addr_t'(y[ROW_W +: PAGE_W]) * addr_t'(SCREEN_WIDTH)
                  + addr_t'(x[COL_W-1:0]);
  assign px.mask  = ROWS_PER_PAGE'(1) << y[ROW_W-1:0];
  assign px.on    = on;
  assign done     = busy && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x         <= start_x;
      y         <= start_y;
      ex        <= end_x;
      ey        <= end_y;
      dx        <= adx;
      dy        <= ady;
      step_xneg <= !(start_x < end_x);
      step_yneg <= !(start_y < end_y);
      err       <= err_init;
      on        <= pixel_on;
    end else if (busy) begin
      if (xstep) begin
        x <= step_xneg ? x - COORD_W'(1) : x + COORD_W'(1);
      end
      if (ystep) begin
        y <= step_yneg ? y - COORD_W'(1) : y + COORD_W'(1);
      end
      err <= err_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/line_raster_into_page_framebuffer.sv =====
// Top level: command decode, line walk, frame store access and result register.
//
//   channel  dir  payload                                        transaction
//   cmd      in   operation, start/end x/y, pixel_on, read addr   one draw or read
//   res      out  read_byte                                      one per cmd
//
// A draw sends one pixel per cycle from the walker into the read-modify-write
// pipe of the frame store. After reset every byte of the store is zeroed, one
// byte a cycle, before cmd.ready rises.
// A result waits in the output register; the next cmd is taken while it waits.
`default_nettype none
module line_raster_into_page_framebuffer
  import lrpf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  lrpf_cmd_if.sink  cmd,
  lrpf_res_if.source res
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_RDWAIT = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t    state, state_next;
  lrpf_req_t walk_px, rd_req, store_req;
  lrpf_rsp_t store_rsp;
  logic      clearing, walk_busy, walk_done;
  logic      accept, start_draw, rd_ok, rd_in_range;
  logic [ROWS_PER_PAGE-1:0] result;
  logic      out_free;

  assign cmd.ready  = (state == ST_IDLE) && !clearing;
  assign accept     = cmd.valid && cmd.ready;
  assign start_draw = accept && (cmd.operation == OP_DRAW);
  assign out_free   = !res.valid || res.ready;

  assign rd_in_range = (int'(cmd.read_page) < PAGE_COUNT)
                    && (int'(cmd.read_column) < SCREEN_WIDTH);

  assign rd_req.valid = accept && (cmd.operation == OP_READ);
  assign rd_req.write = 1'b0;
  assign rd_req.addr  = addr_t'(cmd.read_page) * addr_t'(SCREEN_WIDTH)
                      + addr_t'(cmd.read_column);
  assign rd_req.mask  = '0;
  assign rd_req.on    = 1'b0;

  assign store_req = walk_busy ? walk_px : rd_req;

  lrpf_line_walker u_walker (
    .clk      (clk),
    .rst      (rst),
    .start    (start_draw),
    .start_x  (cmd.start_x),
    .start_y  (cmd.start_y),
    .end_x    (cmd.end_x),
    .end_y    (cmd.end_y),
    .pixel_on (cmd.pixel_on),
    .px       (walk_px),
    .busy     (walk_busy),
    .done     (walk_done)
  );

  lrpf_frame_store u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (store_req),
    .rsp      (store_rsp),
    .clearing (clearing)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (cmd.operation == OP_DRAW) ? ST_WALK : ST_RDWAIT;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_RDWAIT: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ok  <= rd_in_range;
      result <= '0;
    end
    if (state == ST_RDWAIT && store_rsp.valid) begin
      result <= rd_ok ? store_rsp.data : '0;
    end
    if (state == ST_FINISH && out_free) begin
      res.read_byte <= 8'(result);
    end
  end

endmodule
`default_nettype wire

// ===== bench/line_raster_into_page_framebuffer_tb.sv =====
// Self-checking bench for the paged line rasterizer: directed and random draws and reads.
`timescale 1ns / 1ps
`default_nettype none
module line_raster_into_page_framebuffer_tb
  import lrpf_pkg::*;
;

  localparam int RANDOM_CMDS  = 1828;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic               op;
    logic signed [11:0] sx;
    logic signed [11:0] sy;
    logic signed [11:0] ex;
    logic signed [11:0] ey;
    logic               on;
    logic [2:0]         page;
    logic [6:0]         col;
  } raster_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lrpf_cmd_if cmd_if();
  lrpf_res_if res_if();

  line_raster_into_page_framebuffer u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  raster_cmd_t pending_cmds[$];
  logic [7:0]  expected_bytes[$];
  logic [7:0]  shadow_store[STORE_DEPTH];
  int          total_cmds;
  int          accepted_cmds = 0;
  int          send_idle_pct = 18;
  int          recv_idle_pct = 50;
  int          error_count = 0;
  int          cycle_count = 0;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic void plot_pixel(int x, int y, logic on);
    int idx;
    if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_ROWS) return;
    idx = (y / ROWS_PER_PAGE) * SCREEN_WIDTH + x;
    shadow_store[idx][y % ROWS_PER_PAGE] = on;
  endfunction

  // Walks the line into the shadow store, or looks up the byte for a read.
  function automatic logic [7:0] predict_read_byte(raster_cmd_t c);
    int x, y, x1, y1, dx, dy, stx, sty, err, e2;
    if (c.op == OP_READ) begin
      if (c.page < PAGE_COUNT && c.col < SCREEN_WIDTH)
        return shadow_store[c.page * SCREEN_WIDTH + c.col];
      return 8'h00;
    end
    x   = int'(c.sx);
    y   = int'(c.sy);
    x1  = int'(c.ex);
    y1  = int'(c.ey);
    dx  = (x1 > x) ? x1 - x : x - x1;
    dy  = (y1 > y) ? y1 - y : y - y1;
    stx = (x < x1) ? 1 : -1;
    sty = (y < y1) ? 1 : -1;
    err = ((dx > dy) ? dx : -dy) / 2;
    forever begin
      plot_pixel(x, y, c.on);
      if (x == x1 && y == y1) break;
      e2 = err;
      if (e2 > -dx) begin
        err -= dy;
        x += stx;
      end
      if (e2 < dy) begin
        err += dx;
        y += sty;
      end
    end
    return 8'h00;
  endfunction

  // Unused fields get random content.
  function automatic raster_cmd_t make_draw(int sx, int sy, int ex, int ey, logic on);
    raster_cmd_t c;
    c.op   = OP_DRAW;
    c.sx   = sx[11:0];
    c.sy   = sy[11:0];
    c.ex   = ex[11:0];
    c.ey   = ey[11:0];
    c.on   = on;
    c.page = 3'($urandom_range(7));
    c.col  = 7'($urandom_range(127));
    return c;
  endfunction

  function automatic raster_cmd_t make_read(int page, int col);
    raster_cmd_t c;
    c.op   = OP_READ;
    c.sx   = 12'($urandom_range(4095));
    c.sy   = 12'($urandom_range(4095));
    c.ex   = 12'($urandom_range(4095));
    c.ey   = 12'($urandom_range(4095));
    c.on   = 1'($urandom_range(1));
    c.page = page[2:0];
    c.col  = col[6:0];
    return c;
  endfunction

  // Driver
  always @(posedge clk) begin
    raster_cmd_t c;
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else if (!cmd_if.valid || cmd_if.ready) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        c = pending_cmds.pop_front();
        cmd_if.valid       <= 1'b1;
        cmd_if.operation   <= c.op;
        cmd_if.start_x     <= c.sx;
        cmd_if.start_y     <= c.sy;
        cmd_if.end_x       <= c.ex;
        cmd_if.end_y       <= c.ey;
        cmd_if.pixel_on    <= c.on;
        cmd_if.read_page   <= c.page;
        cmd_if.read_column <= c.col;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // Command monitor: predict on each accepted transaction, step the idling phases.
  always @(posedge clk) begin
    raster_cmd_t c;
    if (!rst && cmd_if.valid && cmd_if.ready) begin
      c.op   = cmd_if.operation;
      c.sx   = cmd_if.start_x;
      c.sy   = cmd_if.start_y;
      c.ex   = cmd_if.end_x;
      c.ey   = cmd_if.end_y;
      c.on   = cmd_if.pixel_on;
      c.page = cmd_if.read_page;
      c.col  = cmd_if.read_column;
      expected_bytes.push_back(predict_read_byte(c));
      accepted_cmds++;
      if (accepted_cmds == total_cmds / 3) begin
        send_idle_pct = 50;
        recv_idle_pct = 18;
      end else if (accepted_cmds == 2 * total_cmds / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end
  end

  // Receiver
  always @(posedge clk) begin
    if (rst) res_if.ready <= 1'b0;
    else     res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    logic [7:0] exp_byte;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected transaction: read_byte actual %02h", res_if.read_byte);
        error_count++;
      end else begin
        exp_byte = expected_bytes.pop_front();
        if (res_if.read_byte !== exp_byte) begin
          $error("read_byte mismatch: expected %02h, actual %02h", exp_byte,
                 res_if.read_byte);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int kind, sx, sy, ex, ey;
    cmd_if.valid       = 1'b0;
    cmd_if.operation   = OP_DRAW;
    cmd_if.start_x     = '0;
    cmd_if.start_y     = '0;
    cmd_if.end_x       = '0;
    cmd_if.end_y       = '0;
    cmd_if.pixel_on    = 1'b0;
    cmd_if.read_page   = '0;
    cmd_if.read_column = '0;
    res_if.ready       = 1'b0;
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;

    // Directed: cleared store, extremes, single points, clipping, clears.
    pending_cmds.push_back(make_read(0, 0));
    pending_cmds.push_back(make_read(7, 127));
    pending_cmds.push_back(make_draw(0, 0, 127, 63, 1'b1));
    pending_cmds.push_back(make_read(0, 0));
    pending_cmds.push_back(make_read(7, 127));
    pending_cmds.push_back(make_draw(5, 5, 5, 5, 1'b1));
    pending_cmds.push_back(make_read(0, 5));
    pending_cmds.push_back(make_draw(-2048, -2048, 2047, 2047, 1'b1));
    pending_cmds.push_back(make_draw(2047, -2048, -2048, 2047, 1'b1));
    pending_cmds.push_back(make_read(3, 30));
    pending_cmds.push_back(make_draw(-10, 10, 140, 10, 1'b1));
    pending_cmds.push_back(make_draw(20, -5, 20, 70, 1'b1));
    pending_cmds.push_back(make_read(1, 20));
    pending_cmds.push_back(make_read(7, 20));
    pending_cmds.push_back(make_draw(100, 63, 90, 0, 1'b1));
    pending_cmds.push_back(make_draw(200, 5, 200, 5, 1'b1));
    pending_cmds.push_back(make_draw(-1, -1, -1, -1, 1'b1));
    pending_cmds.push_back(make_draw(127, 0, 0, 0, 1'b1));
    pending_cmds.push_back(make_read(0, 64));
    pending_cmds.push_back(make_draw(0, 0, 127, 63, 1'b0));
    pending_cmds.push_back(make_draw(5, 5, 5, 5, 1'b0));
    pending_cmds.push_back(make_read(0, 5));
    pending_cmds.push_back(make_read(7, 127));
    pending_cmds.push_back(make_read(5, 95));

    // Random: reads, short and longer lines near the screen, some clipped, a few full range.
    repeat (RANDOM_CMDS) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        pending_cmds.push_back(make_read($urandom_range(7), $urandom_range(127)));
      end else if (kind < 38) begin
        pending_cmds.push_back(make_draw($urandom_range(4095) - 2048,
                                         $urandom_range(4095) - 2048,
                                         $urandom_range(4095) - 2048,
                                         $urandom_range(4095) - 2048,
                                         1'($urandom_range(1))));
      end else begin
        sx = $urandom_range(SCREEN_WIDTH + 31) - 16;
        sy = $urandom_range(SCREEN_ROWS + 31) - 16;
        if (kind < 70) begin
          ex = sx + $urandom_range(16) - 8;
          ey = sy + $urandom_range(16) - 8;
        end else begin
          ex = $urandom_range(SCREEN_WIDTH + 31) - 16;
          ey = $urandom_range(SCREEN_ROWS + 31) - 16;
        end
        pending_cmds.push_back(make_draw(sx, sy, ex, ey, 1'($urandom_range(1))));
      end
    end
    total_cmds = pending_cmds.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || cmd_if.valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/lrpf_pkg.sv
hw/rtl/lrpf_if.sv
hw/rtl/lrpf_frame_store.sv
hw/rtl/lrpf_line_walker.sv
hw/rtl/line_raster_into_page_framebuffer.sv
bench/line_raster_into_page_framebuffer_tb.sv
